// ----- rtl/pip_pkg.sv -----
`timescale 1ns / 1ps

package pip_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 23;
    localparam int MUL_W   = 27;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] CFG_CIRCLE_MODE   = 2'd0;
    localparam logic [1:0] CFG_CIRCLE_RADIUS = 2'd1;
    localparam logic [1:0] CFG_OFFSET_X      = 2'd2;
    localparam logic [1:0] CFG_OFFSET_Y      = 2'd3;

    // Multiplier operand pairs.
    localparam logic [2:0] MUL_PX_DYE = 3'd0;
    localparam logic [2:0] MUL_RX_DYE = 3'd1;
    localparam logic [2:0] MUL_PY_DXE = 3'd2;
    localparam logic [2:0] MUL_DX_SQ  = 3'd3;
    localparam logic [2:0] MUL_DY_SQ  = 3'd4;
    localparam logic [2:0] MUL_RAD_SQ = 3'd5;

    // Far end of the ray: x = 100000 in Q18.8.
    localparam logic signed [MUL_W-1:0] RAY_END_X = 27'sd25600000;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } pip_in_t;

    typedef struct packed {
        logic       is_inside;
        logic [1:0] status;
    } pip_result_t;

    typedef struct packed {
        logic       latch_pt;
        logic       clear;
        logic       append;
        logic       take_first;
        logic       load_b;
        logic       load_diff;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       eval_edge;
        logic       eval_circle;
    } pip_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic last_edge;
        logic circle;
        logic in_shape;
    } pip_stat_t;

endpackage

// ----- rtl/pip_datapath.sv -----
`timescale 1ns / 1ps

module pip_datapath #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pip_pkg::pip_in_t           item,
    input  logic                       cfg_valid,
    input  logic [1:0]                 cfg_index,
    input  logic [pip_pkg::COORD_W-1:0] cfg_data,
    input  pip_pkg::pip_cmd_t          cmd,
    output pip_pkg::pip_stat_t         stat
);

    localparam int AW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW      = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W = pip_pkg::COORD_W;
    localparam int RAD_W   = pip_pkg::RAD_W;
    localparam int MUL_W   = pip_pkg::MUL_W;
    localparam int PROD_W  = pip_pkg::PROD_W;
    localparam int SUM_W   = pip_pkg::SUM_W;
    localparam int VW      = COORD_W + 1;

    // Configuration registers.
    logic                      circle_mode_reg;
    logic [RAD_W-1:0]          radius_reg;
    logic signed [COORD_W-1:0] offset_x_reg;
    logic signed [COORD_W-1:0] offset_y_reg;

    // Vertex table.
    logic [COORD_W-1:0] vx_mem [MAX_VERTICES];
    logic [COORD_W-1:0] vy_mem [MAX_VERTICES];
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] edge_reg;

    // Query point, edge end points (offset applied) and first vertex.
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [VW-1:0]      a_x_reg, a_y_reg, b_x_reg, b_y_reg;

    // Differences, products and flags.
    logic signed [MUL_W-1:0]  dxp_reg, drx_reg, dya_reg, dye_reg, dxe_reg;
    logic                     straddle_reg;
    logic signed [PROD_W-1:0] prod_reg, m1_reg, m2_reg;
    logic                     inside_reg;

    logic signed [VW-1:0]     off_x_ext, off_y_ext;
    logic signed [VW-1:0]     sel_x, sel_y;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [SUM_W-1:0]  s2_diff, s3_diff, dist_sq, rad_sq;
    logic                     last_edge;
    logic                     edge_hit;

    assign off_x_ext = VW'(offset_x_reg);
    assign off_y_ext = VW'(offset_y_reg);
    assign last_edge = ((edge_reg + CW'(1)) == count_reg);

    // The closing edge returns to vertex 0.
    assign sel_x = (cmd.load_b && last_edge) ? VW'(first_x_reg) : VW'(rd_x_reg);
    assign sel_y = (cmd.load_b && last_edge) ? VW'(first_y_reg) : VW'(rd_y_reg);

    always_comb
    begin
        rd_addr_next = rd_addr_reg;
        if (cmd.latch_pt)
        begin
            rd_addr_next = '0;
        end
        else if (cmd.take_first)
        begin
            rd_addr_next = AW'(1);
        end
        else if (cmd.eval_edge)
        begin
            rd_addr_next = rd_addr_reg + AW'(1);
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            pip_pkg::MUL_PX_DYE:
            begin
                mul_a = dxp_reg;
                mul_b = dye_reg;
            end
            pip_pkg::MUL_RX_DYE:
            begin
                mul_a = drx_reg;
                mul_b = dye_reg;
            end
            pip_pkg::MUL_PY_DXE:
            begin
                mul_a = dya_reg;
                mul_b = dxe_reg;
            end
            pip_pkg::MUL_DX_SQ:
            begin
                mul_a = dxp_reg;
                mul_b = dxp_reg;
            end
            pip_pkg::MUL_DY_SQ:
            begin
                mul_a = dya_reg;
                mul_b = dya_reg;
            end
            default:
            begin
                mul_a = signed'(MUL_W'(radius_reg));
                mul_b = signed'(MUL_W'(radius_reg));
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Edge equation at the query point and at the ray end, both against
    // the shared term (py - ay) * (bx - ax).
    assign s2_diff = SUM_W'(m1_reg) - SUM_W'(prod_reg);
    assign s3_diff = SUM_W'(m2_reg) - SUM_W'(prod_reg);
    assign edge_hit = straddle_reg &&
                      !((s2_diff > 0 && s3_diff > 0) || (s2_diff < 0 && s3_diff < 0));

    assign dist_sq = SUM_W'(m1_reg) + SUM_W'(m2_reg);
    assign rad_sq  = SUM_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_mode_reg <= 1'b0;
            radius_reg      <= '0;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pip_pkg::CFG_CIRCLE_MODE:   circle_mode_reg <= cfg_data[0];
                pip_pkg::CFG_CIRCLE_RADIUS: radius_reg      <= cfg_data[RAD_W-1:0];
                pip_pkg::CFG_OFFSET_X:      offset_x_reg    <= signed'(cfg_data);
                pip_pkg::CFG_OFFSET_Y:      offset_y_reg    <= signed'(cfg_data);
                default:                    circle_mode_reg <= circle_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            edge_reg    <= '0;
            rd_addr_reg <= '0;
            inside_reg  <= 1'b0;
        end
        else
        begin
            rd_addr_reg <= rd_addr_next;
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.latch_pt)
            begin
                inside_reg <= 1'b0;
            end
            else if (cmd.eval_edge)
            begin
                inside_reg <= inside_reg ^ edge_hit;
            end
            else if (cmd.eval_circle)
            begin
                inside_reg <= (dist_sq <= rad_sq);
            end
            if (cmd.take_first)
            begin
                edge_reg <= '0;
            end
            else if (cmd.eval_edge)
            begin
                edge_reg <= edge_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            vx_mem[count_reg[AW-1:0]] <= item.coord_x;
            vy_mem[count_reg[AW-1:0]] <= item.coord_y;
        end
        rd_x_reg <= signed'(vx_mem[rd_addr_next]);
        rd_y_reg <= signed'(vy_mem[rd_addr_next]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_pt)
        begin
            px_reg <= item.coord_x;
            py_reg <= item.coord_y;
        end
        if (cmd.take_first)
        begin
            first_x_reg <= rd_x_reg;
            first_y_reg <= rd_y_reg;
            a_x_reg     <= VW'(rd_x_reg) + off_x_ext;
            a_y_reg     <= VW'(rd_y_reg) + off_y_ext;
        end
        else if (cmd.eval_edge)
        begin
            a_x_reg <= b_x_reg;
            a_y_reg <= b_y_reg;
        end
        if (cmd.load_b)
        begin
            b_x_reg <= sel_x + off_x_ext;
            b_y_reg <= sel_y + off_y_ext;
        end
        if (cmd.load_diff)
        begin
            dxp_reg      <= MUL_W'(px_reg) - MUL_W'(a_x_reg);
            drx_reg      <= pip_pkg::RAY_END_X - MUL_W'(a_x_reg);
            dya_reg      <= MUL_W'(py_reg) - MUL_W'(a_y_reg);
            dye_reg      <= MUL_W'(b_y_reg) - MUL_W'(a_y_reg);
            dxe_reg      <= MUL_W'(b_x_reg) - MUL_W'(a_x_reg);
            straddle_reg <= !((a_y_reg > VW'(py_reg) && b_y_reg > VW'(py_reg)) ||
                              (a_y_reg < VW'(py_reg) && b_y_reg < VW'(py_reg)));
        end
        if (cmd.mul_en)
        begin
            prod_reg <= product;
            m2_reg   <= prod_reg;
            m1_reg   <= m2_reg;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CW'(MAX_VERTICES));
    assign stat.last_edge  = last_edge;
    assign stat.circle     = circle_mode_reg;
    assign stat.in_shape   = inside_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond table depth");

    a_no_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !stat.count_full)
        else $error("append into a full table");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_edge |-> (edge_reg < count_reg))
        else $error("edge evaluated past the last vertex");
`endif

endmodule

// ----- rtl/pip_ctrl.sv -----
`timescale 1ns / 1ps

module pip_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           kind,
    output logic                 busy,
    output logic                 done,
    output pip_pkg::pip_result_t result,
    output pip_pkg::pip_cmd_t    cmd,
    input  pip_pkg::pip_stat_t   stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_LOADB  = 4'd2;
    localparam logic [3:0] S_DIFF   = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_MUL3   = 4'd6;
    localparam logic [3:0] S_EVAL   = 4'd7;
    localparam logic [3:0] S_REPORT = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic                 done_reg, done_next;
    pip_pkg::pip_result_t result_reg, result_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next          = 1'b1;
                    result_next.is_inside = 1'b0;
                    result_next.status = pip_pkg::STATUS_OK;
                    unique case (kind)
                        pip_pkg::KIND_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        pip_pkg::KIND_APPEND:
                        begin
                            if (stat.count_full)
                            begin
                                result_next.status = pip_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                            end
                        end
                        pip_pkg::KIND_QUERY:
                        begin
                            if (stat.count_zero)
                            begin
                                result_next.status = pip_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                done_next    = 1'b0;
                                cmd.latch_pt = 1'b1;
                                state_next   = S_FIRST;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                cmd.take_first = 1'b1;
                state_next     = stat.circle ? S_DIFF : S_LOADB;
            end
            S_LOADB:
            begin
                cmd.load_b = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.load_diff = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = stat.circle ? pip_pkg::MUL_DX_SQ : pip_pkg::MUL_PX_DYE;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = stat.circle ? pip_pkg::MUL_DY_SQ : pip_pkg::MUL_RX_DYE;
                state_next  = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = stat.circle ? pip_pkg::MUL_RAD_SQ : pip_pkg::MUL_PY_DXE;
                state_next  = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.circle)
                begin
                    cmd.eval_circle = 1'b1;
                    state_next      = S_REPORT;
                end
                else
                begin
                    cmd.eval_edge = 1'b1;
                    state_next    = stat.last_edge ? S_REPORT : S_LOADB;
                end
            end
            S_REPORT:
            begin
                done_next             = 1'b1;
                result_next.is_inside = stat.in_shape;
                result_next.status    = pip_pkg::STATUS_OK;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |=> (done_reg && state_reg == S_IDLE))
        else $error("query finished without a result transfer");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_REPORT ||
                      ($past(state_reg) == S_IDLE && $past(start))))
        else $error("result strobe without a finished item");
`endif

endmodule

// ----- rtl/point_in_polygon_test.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// item      start, busy              item (kind, coord_x, coord_y)
// result    done strobe              result (is_inside, status)
// config    cfg_valid, cfg_ready     cfg_index, cfg_data
//
// Clear, append, unused kinds and a query on an empty table give their
// result in the cycle after the transfer and leave the block idle.
// A circle or polygon query runs through the single 27 x 27 multiplier; a
// polygon query over N stored vertices takes one edge at a time.
// rst_n clears the vertex count and the configuration; table contents stay.
// Results are strobed on done for one cycle and cannot be held off.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pip_pkg::pip_in_t            item,
    output logic                        done,
    output pip_pkg::pip_result_t        result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [pip_pkg::COORD_W-1:0] cfg_data
);

    pip_pkg::pip_cmd_t  cmd;
    pip_pkg::pip_stat_t stat;

    assign cfg_ready = 1'b1;

    pip_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .busy   (busy),
        .done   (done),
        .result (result),
        .cmd    (cmd),
        .stat   (stat)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W = pip_pkg::COORD_W;
    localparam int RAD_W = pip_pkg::RAD_W;
    localparam int MAX_VERTS = 32;
    localparam int ITEM_GOAL = 1500;
    localparam longint RAY_FAR_X = 64'sd100000 * 256;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint COORD_MIN = -(64'sd1 << (COORD_W - 1));
    localparam longint COORD_MAX = (64'sd1 << (COORD_W - 1)) - 1;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pip_pkg::pip_in_t     item;
    logic                 done;
    pip_pkg::pip_result_t result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    // Shadow copy of the vertex table and the registers.
    logic signed [COORD_W-1:0] shadow_x [MAX_VERTS];
    logic signed [COORD_W-1:0] shadow_y [MAX_VERTS];
    int                        stored_count = 0;
    logic                      circle_on = 1'b0;
    logic [RAD_W-1:0]          radius = '0;
    logic signed [COORD_W-1:0] off_x = '0;
    logic signed [COORD_W-1:0] off_y = '0;

    pip_pkg::pip_result_t verdicts_due[$];
    int                   mismatches = 0;
    int                   items_sent = 0;
    bit                   eager = 1'b0;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic longint fit24(longint v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic longint srand(longint lo, longint hi);
        return lo + longint'($urandom_range(int'(hi - lo), 0));
    endfunction

    function automatic int cross_sign(longint ax, ay, bx, by, px, py);
        longint v;
        v = (px - ax) * (by - ay) - (py - ay) * (bx - ax);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Closed-segment intersection of the ray from (px, py) with edge a-b.
    function automatic bit ray_meets_edge(longint px, py, ax, ay, bx, by);
        int s0, s1, s2, s3;
        s0 = cross_sign(px, py, RAY_FAR_X, py, ax, ay);
        s1 = cross_sign(px, py, RAY_FAR_X, py, bx, by);
        s2 = cross_sign(ax, ay, bx, by, px, py);
        s3 = cross_sign(ax, ay, bx, by, RAY_FAR_X, py);
        return (s0 * s1 <= 0) && (s2 * s3 <= 0);
    endfunction

    function automatic pip_pkg::pip_result_t judge_item(pip_pkg::pip_in_t it);
        pip_pkg::pip_result_t r;
        longint px, py, ax, ay, bx, by, dx, dy, rr;
        int hits, nxt;
        r = '0;
        px = it.coord_x;
        py = it.coord_y;
        case (it.kind)
            pip_pkg::KIND_CLEAR: stored_count = 0;
            pip_pkg::KIND_APPEND:
            begin
                if (stored_count >= MAX_VERTS)
                    r.status = pip_pkg::STATUS_FULL;
                else
                begin
                    shadow_x[stored_count] = it.coord_x;
                    shadow_y[stored_count] = it.coord_y;
                    stored_count++;
                end
            end
            pip_pkg::KIND_QUERY:
            begin
                if (stored_count == 0)
                    r.status = pip_pkg::STATUS_EMPTY;
                else if (circle_on)
                begin
                    dx = px - (longint'(shadow_x[0]) + longint'(off_x));
                    dy = py - (longint'(shadow_y[0]) + longint'(off_y));
                    rr = radius;
                    r.is_inside = (dx * dx + dy * dy) <= rr * rr;
                end
                else
                begin
                    hits = 0;
                    for (int k = 0; k < stored_count; k++)
                    begin
                        nxt = (k + 1 < stored_count) ? k + 1 : 0;
                        ax = longint'(shadow_x[k]) + longint'(off_x);
                        ay = longint'(shadow_y[k]) + longint'(off_y);
                        bx = longint'(shadow_x[nxt]) + longint'(off_x);
                        by = longint'(shadow_y[nxt]) + longint'(off_y);
                        if (ray_meets_edge(px, py, ax, ay, bx, by))
                            hits++;
                    end
                    r.is_inside = hits[0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        pip_pkg::pip_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (verdicts_due.size() == 0)
                flag_mismatch("result strobed with no item outstanding");
            else
            begin
                want = verdicts_due.pop_front();
                if (result.is_inside !== want.is_inside)
                    flag_mismatch($sformatf("is_inside %b, expected %b",
                                            result.is_inside, want.is_inside));
                if (result.status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            result.status, want.status));
            end
        end
    end

    task automatic send_item(logic [1:0] k, longint x, longint y);
        pip_pkg::pip_in_t it;
        pip_pkg::pip_result_t due;
        int gap;
        it.kind = k;
        it.coord_x = fit24(x);
        it.coord_y = fit24(y);
        gap = eager ? 0 : $urandom_range(3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        due = judge_item(it);
        verdicts_due = {verdicts_due, due};
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    // Holds off new items until every outstanding result has come back.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            pip_pkg::CFG_CIRCLE_MODE:   circle_on = data[0];
            pip_pkg::CFG_CIRCLE_RADIUS: radius = data[RAD_W-1:0];
            pip_pkg::CFG_OFFSET_X:      off_x = data;
            pip_pkg::CFG_OFFSET_Y:      off_y = data;
            default: ;
        endcase
    endtask

    task automatic test_empty_and_unused();
        send_item(pip_pkg::KIND_QUERY, 0, 0);
        send_item(KIND_UNUSED, srand(COORD_MIN, COORD_MAX), srand(COORD_MIN, COORD_MAX));
        send_item(pip_pkg::KIND_CLEAR, 0, 0);
        send_item(pip_pkg::KIND_QUERY, COORD_MAX, COORD_MIN);
    endtask

    // A lone vertex is a degenerate edge: only points on its ray see it.
    task automatic test_single_vertex();
        send_item(pip_pkg::KIND_APPEND, 256, 512);
        send_item(pip_pkg::KIND_QUERY, -1000, 512);
        send_item(pip_pkg::KIND_QUERY, 256, 512);
        send_item(pip_pkg::KIND_QUERY, 300, 512);
        send_item(pip_pkg::KIND_QUERY, 0, 513);
    endtask

    task automatic test_square();
        send_item(pip_pkg::KIND_CLEAR, 0, 0);
        send_item(pip_pkg::KIND_APPEND, 0, 0);
        send_item(pip_pkg::KIND_APPEND, 1024, 0);
        send_item(pip_pkg::KIND_APPEND, 1024, 1024);
        send_item(pip_pkg::KIND_APPEND, 0, 1024);
        send_item(pip_pkg::KIND_QUERY, 512, 512);
        send_item(pip_pkg::KIND_QUERY, 2000, 512);
        send_item(pip_pkg::KIND_QUERY, 1024, 512);
        send_item(pip_pkg::KIND_QUERY, 512, 0);
        send_item(pip_pkg::KIND_QUERY, 0, 1024);
        send_item(pip_pkg::KIND_QUERY, COORD_MAX, COORD_MAX);
        send_item(pip_pkg::KIND_QUERY, COORD_MIN, COORD_MIN);
        send_item(pip_pkg::KIND_QUERY, COORD_MIN, 512);
    endtask

    task automatic test_offset_extremes();
        write_reg(pip_pkg::CFG_OFFSET_X, 24'h7fffff);
        write_reg(pip_pkg::CFG_OFFSET_Y, 24'h800000);
        send_item(pip_pkg::KIND_QUERY, COORD_MAX, COORD_MIN + 512);
        send_item(pip_pkg::KIND_QUERY, COORD_MAX, COORD_MIN);
        write_reg(pip_pkg::CFG_OFFSET_X, 24'h800000);
        write_reg(pip_pkg::CFG_OFFSET_Y, 24'h7fffff);
        send_item(pip_pkg::KIND_QUERY, COORD_MIN, COORD_MAX);
        send_item(pip_pkg::KIND_QUERY, COORD_MIN + 512, COORD_MAX);
        write_reg(pip_pkg::CFG_OFFSET_X, '0);
        write_reg(pip_pkg::CFG_OFFSET_Y, '0);
    endtask

    task automatic test_table_full();
        send_item(pip_pkg::KIND_CLEAR, 0, 0);
        for (int k = 0; k < MAX_VERTS; k++)
            send_item(pip_pkg::KIND_APPEND, srand(-4096, 4096), srand(-4096, 4096));
        send_item(pip_pkg::KIND_APPEND, 12, 34);
        send_item(pip_pkg::KIND_QUERY, 0, 0);
        send_item(pip_pkg::KIND_CLEAR, 0, 0);
        send_item(pip_pkg::KIND_QUERY, 0, 0);
    endtask

    task automatic test_circle();
        write_reg(pip_pkg::CFG_CIRCLE_MODE, 24'd1);
        write_reg(pip_pkg::CFG_CIRCLE_RADIUS, 24'd1024);
        send_item(pip_pkg::KIND_QUERY, 256, 256);
        send_item(pip_pkg::KIND_APPEND, 256, 256);
        send_item(pip_pkg::KIND_APPEND, 9000, -9000);
        send_item(pip_pkg::KIND_QUERY, 256, 256);
        send_item(pip_pkg::KIND_QUERY, 256 + 1024, 256);
        send_item(pip_pkg::KIND_QUERY, 256 + 1025, 256);
        send_item(pip_pkg::KIND_QUERY, 256 + 724, 256 - 724);
        write_reg(pip_pkg::CFG_CIRCLE_RADIUS, 24'h7fffff);
        send_item(pip_pkg::KIND_QUERY, COORD_MIN, COORD_MIN);
        send_item(pip_pkg::KIND_QUERY, COORD_MAX, 256);
        write_reg(pip_pkg::CFG_CIRCLE_RADIUS, '0);
        send_item(pip_pkg::KIND_QUERY, 256, 256);
        send_item(pip_pkg::KIND_QUERY, 257, 256);
        write_reg(pip_pkg::CFG_CIRCLE_MODE, '0);
    endtask

    function automatic logic [COORD_W-1:0] pick_offset();
        case ($urandom_range(5))
            2: return 24'h7fffff;
            3: return 24'h800000;
            4: return COORD_W'(srand(-2048, 2048));
            5: return COORD_W'($urandom);
            default: return '0;
        endcase
    endfunction

    task automatic random_setting();
        logic [COORD_W-1:0] r;
        write_reg(pip_pkg::CFG_CIRCLE_MODE, ($urandom_range(3) == 0) ? 24'd1 : 24'd0);
        case ($urandom_range(4))
            0: r = '0;
            1: r = 24'h7fffff;
            2: r = COORD_W'($urandom_range(8388607));
            default: r = COORD_W'($urandom_range(4096));
        endcase
        write_reg(pip_pkg::CFG_CIRCLE_RADIUS, r);
        write_reg(pip_pkg::CFG_OFFSET_X, pick_offset());
        write_reg(pip_pkg::CFG_OFFSET_Y, pick_offset());
    endtask

    task automatic random_shape();
        longint xs[$], ys[$];
        longint cx, cy, span, px, py, reach, x, y;
        int n, pick, sel, k, m;
        bit snap;
        eager = ($urandom_range(3) == 0);
        if ($urandom_range(15) == 0)
        begin
            // Noise: any kind, any coordinates.
            repeat ($urandom_range(12, 4))
                send_item(2'($urandom_range(3)), srand(COORD_MIN, COORD_MAX),
                          srand(COORD_MIN, COORD_MAX));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 5)
            n = 0;
        else if (pick < 12)
            n = $urandom_range(2, 1);
        else if (pick < 85)
            n = $urandom_range(8, 3);
        else if (pick < 95)
            n = $urandom_range(20, 9);
        else
            n = $urandom_range(MAX_VERTS + 3, MAX_VERTS - 4);
        span = ($urandom_range(9) == 0) ? (64'sd1 << 22) : srand(256, 4096);
        cx = srand(COORD_MIN + span, COORD_MAX - span);
        cy = srand(COORD_MIN + span, COORD_MAX - span);
        if ($urandom_range(1) == 0)
        begin
            cx = 0;
            cy = 0;
        end
        snap = ($urandom_range(1) == 1);
        send_item(pip_pkg::KIND_CLEAR, srand(COORD_MIN, COORD_MAX),
                  srand(COORD_MIN, COORD_MAX));
        repeat (n)
        begin
            x = fit24(cx + srand(-span, span));
            y = fit24(cy + srand(-span, span));
            if (snap)
            begin
                x = x & ~64'sd255;
                y = y & ~64'sd255;
            end
            xs = {xs, x};
            ys = {ys, y};
            send_item(pip_pkg::KIND_APPEND, x, y);
        end
        repeat ($urandom_range(10, 3))
        begin
            sel = $urandom_range(9);
            if (xs.size() == 0)
                sel = 0;
            px = cx + srand(-span - span / 4, span + span / 4) + off_x;
            py = cy + srand(-span - span / 4, span + span / 4) + off_y;
            k = $urandom_range(xs.size() - 1);
            m = (k + 1) % ((xs.size() == 0) ? 1 : xs.size());
            if (circle_on && sel < 6 && xs.size() != 0)
            begin
                reach = longint'(radius) + longint'(radius) / 8 + 2;
                px = xs[0] + off_x + srand(-reach, reach);
                py = ys[0] + off_y + srand(-reach, reach);
            end
            else
            begin
                case (sel % 5)
                    1:
                    begin
                        px = xs[k] + off_x;
                        py = ys[k] + off_y;
                    end
                    2:
                    begin
                        px = (xs[k] + xs[m]) / 2 + off_x;
                        py = (ys[k] + ys[m]) / 2 + off_y;
                    end
                    3: py = ys[k] + off_y;
                    4:
                    begin
                        px = srand(COORD_MIN, COORD_MAX);
                        py = srand(COORD_MIN, COORD_MAX);
                    end
                    default: ;
                endcase
            end
            send_item(pip_pkg::KIND_QUERY, px, py);
        end
    endtask

    task automatic test_random_shapes();
        while (items_sent < ITEM_GOAL)
        begin
            random_setting();
            repeat (8) random_shape();
        end
        eager = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unused();
        test_single_vertex();
        test_square();
        test_offset_extremes();
        test_table_full();
        test_circle();
        test_random_shapes();

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
